// ===== hw/rtl/led_pwm_effects_with_buzzer_core_assert.svh =====
// ----------------------------------------------------------------------------
// LED PWM effects core: assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LED_PWM_EFFECTS_WITH_BUZZER_CORE_ASSERT_SVH
`define LED_PWM_EFFECTS_WITH_BUZZER_CORE_ASSERT_SVH

// Same-cycle implication
`define LPE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define LPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Delayed implication
`define LPE_ASSERT_AFTER2(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpe_pkg
// Types and constants shared by the LED PWM effects core.
// ----------------------------------------------------------------------------
`default_nettype none

package lpe_pkg;

   localparam int CHANNELS_DEFAULT = 5;
   localparam int BUZZER_CH        = 4;

   localparam logic [9:0]  PHASE_WRAP = 10'd1000;
   localparam logic [9:0]  PHASE_HALF = 10'd500;
   localparam logic [7:0]  BUZZ_DUTY  = 8'd128;
   localparam logic [7:0]  COUNT_TOP  = 8'd255;
   localparam logic [15:0] TICK_MS    = 16'd10;
   localparam logic [15:0] STEP_RESET = 16'd10;

   // Reciprocal of 500 scaled by 2^27; exact for products below 2^27 / 272
   localparam int          RECIP_SHIFT  = 27;
   localparam int          SCALED_WIDTH = 27;
   localparam logic [18:0] RECIP        = 19'd268436;

   typedef enum logic [3:0] {
      OP_TICK       = 4'd0,
      OP_SET_DUTY   = 4'd1,
      OP_SET_TARGET = 4'd2,
      OP_FADE       = 4'd3,
      OP_SET_MODE   = 4'd4,
      OP_ENABLE     = 4'd5,
      OP_BEEP       = 4'd6,
      OP_PATTERN    = 4'd7,
      OP_STOP       = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      MODE_STATIC = 2'd0,
      MODE_BREATH = 2'd1,
      MODE_FLASH  = 2'd2,
      MODE_FADE   = 2'd3
   } mode_type;

   typedef struct packed {
      op_type                    operation;
      logic [2:0]                channel;
      logic [7:0]                level;
      logic [SCALED_WIDTH-1:0]   level_scaled;
      logic [15:0]               speed;
      mode_type                  effect_mode;
      logic                      enable_flag;
      logic [15:0]               on_time_ms;
      logic [15:0]               off_time_ms;
      logic [7:0]                repeat_count;
   } cmd_type;

   typedef struct packed {
      logic       write;
      logic [7:0] duty;
   } buzz_duty_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lpe_channel.sv =====
// ----------------------------------------------------------------------------
// lpe_channel
// State and effect update of one PWM channel, plus its pin level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_channel import lpe_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire cmd_type       cmd,
   input  wire logic          hit,
   input  wire buzz_duty_type buzz_duty,
   input  wire logic [7:0]    count_in,
   output logic               pin_out
);

   logic [7:0]              duty_ff,    duty_in;
   logic [7:0]              target_ff,  target_in;
   logic [SCALED_WIDTH-1:0] scaled_ff,  scaled_in;
   logic [9:0]              phase_ff,   phase_in;
   logic [15:0]             speed_ff,   speed_in;
   mode_type                mode_ff,    mode_in;
   logic                    enabled_ff, enabled_in;

   logic [16:0]                      phase_sum;
   logic [9:0]                       phase_step;
   logic [8:0]                       tri_x;
   logic [SCALED_WIDTH+8:0]          breath_prod;
   logic [7:0]                       breath_duty;
   logic [7:0]                       up_gap;
   logic [7:0]                       down_gap;
   logic [7:0]                       fade_duty;

   // Phase advance and triangle breathing level
   always_comb begin
      phase_sum   = {7'd0, phase_ff} + {1'b0, speed_ff};
      phase_step  = (phase_sum >= 17'(PHASE_WRAP)) ? '0 : phase_sum[9:0];
      tri_x       = (phase_step < PHASE_HALF) ? phase_step[8:0]
                                              : 9'(PHASE_WRAP - phase_step);
      breath_prod = (SCALED_WIDTH+9)'(tri_x) * (SCALED_WIDTH+9)'(scaled_ff);
      breath_duty = breath_prod[RECIP_SHIFT +: 8];
   end

   // Fade one step toward the target, clamping at it
   always_comb begin
      up_gap   = target_ff - duty_ff;
      down_gap = duty_ff - target_ff;
      if (duty_ff < target_ff) begin
         fade_duty = (speed_ff >= {8'd0, up_gap}) ? target_ff : duty_ff + speed_ff[7:0];
      end else if (duty_ff > target_ff) begin
         fade_duty = (speed_ff <= {8'd0, down_gap}) ? duty_ff - speed_ff[7:0] : target_ff;
      end else begin
         fade_duty = duty_ff;
      end
   end

   // Next state for the item in the input register
   always_comb begin
      duty_in    = duty_ff;
      target_in  = target_ff;
      scaled_in  = scaled_ff;
      phase_in   = phase_ff;
      speed_in   = speed_ff;
      mode_in    = mode_ff;
      enabled_in = enabled_ff;
      case (cmd.operation)
         OP_TICK: begin
            if (enabled_ff) begin
               case (mode_ff)
                  MODE_BREATH: begin
                     phase_in = phase_step;
                     duty_in  = breath_duty;
                  end
                  MODE_FLASH: begin
                     phase_in = phase_step;
                     duty_in  = (phase_step < PHASE_HALF) ? target_ff : '0;
                  end
                  MODE_FADE: begin
                     duty_in = fade_duty;
                  end
                  default: ;
               endcase
            end
         end
         OP_SET_DUTY: begin
            if (hit) begin
               duty_in   = cmd.level;
               target_in = cmd.level;
               scaled_in = cmd.level_scaled;
               mode_in   = MODE_STATIC;
            end
         end
         OP_SET_TARGET: begin
            if (hit) begin
               target_in = cmd.level;
               scaled_in = cmd.level_scaled;
            end
         end
         OP_FADE: begin
            if (hit) begin
               target_in = cmd.level;
               scaled_in = cmd.level_scaled;
               speed_in  = cmd.speed;
               mode_in   = MODE_FADE;
            end
         end
         OP_SET_MODE: begin
            if (hit) begin
               mode_in  = cmd.effect_mode;
               speed_in = cmd.speed;
               phase_in = '0;
            end
         end
         OP_ENABLE: begin
            if (hit) begin
               enabled_in = cmd.enable_flag;
               if (!cmd.enable_flag) begin
                  duty_in = '0;
               end
            end
         end
         default: ;
      endcase
      // Buzzer sequencer writes land after the effect update
      if (buzz_duty.write) begin
         duty_in = buzz_duty.duty;
      end
   end

   assign pin_out = enabled_in && (count_in < duty_in);

   // Hold channel state; advance on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff    <= '0;
         target_ff  <= '0;
         scaled_ff  <= '0;
         phase_ff   <= '0;
         speed_ff   <= STEP_RESET;
         mode_ff    <= MODE_STATIC;
         enabled_ff <= 1'b1;
      end else if (fire) begin
         duty_ff    <= duty_in;
         target_ff  <= target_in;
         scaled_ff  <= scaled_in;
         phase_ff   <= phase_in;
         speed_ff   <= speed_in;
         mode_ff    <= mode_in;
         enabled_ff <= enabled_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lpe_buzzer.sv =====
// ----------------------------------------------------------------------------
// lpe_buzzer
// Beep and on/off pattern timer; issues duty writes to the buzzer channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_buzzer import lpe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire cmd_type cmd,
   output buzz_duty_type duty_wr
);

   logic [15:0] timer_ff,    timer_in;
   logic [7:0]  reps_ff,     reps_in;
   logic [15:0] on_ff,       on_in;
   logic [15:0] off_ff,      off_in;
   logic        sounding_ff, sounding_in;
   logic [15:0] timer_dec;

   // Count down in 10 ms steps, saturating at zero
   assign timer_dec = (timer_ff > TICK_MS) ? timer_ff - TICK_MS : '0;

   always_comb begin
      timer_in    = timer_ff;
      reps_in     = reps_ff;
      on_in       = on_ff;
      off_in      = off_ff;
      sounding_in = sounding_ff;
      duty_wr     = '0;
      case (cmd.operation)
         OP_TICK: begin
            if (timer_ff != '0) begin
               timer_in = timer_dec;
               // Timer expired: toggle pattern phase or end the beep
               if (timer_dec == '0) begin
                  if (reps_ff != '0) begin
                     if (!sounding_ff) begin
                        sounding_in = 1'b1;
                        timer_in    = on_ff;
                        duty_wr     = '{write: 1'b1, duty: BUZZ_DUTY};
                     end else begin
                        sounding_in = 1'b0;
                        timer_in    = off_ff;
                        duty_wr     = '{write: 1'b1, duty: 8'd0};
                        reps_in     = reps_ff - 8'd1;
                     end
                  end else begin
                     duty_wr = '{write: 1'b1, duty: 8'd0};
                  end
               end
            end
         end
         OP_BEEP: begin
            timer_in = cmd.on_time_ms;
            reps_in  = '0;
            duty_wr  = '{write: 1'b1, duty: BUZZ_DUTY};
         end
         OP_PATTERN: begin
            reps_in     = cmd.repeat_count;
            on_in       = cmd.on_time_ms;
            off_in      = cmd.off_time_ms;
            sounding_in = 1'b0;
            timer_in    = 16'd1;
         end
         OP_STOP: begin
            timer_in = '0;
            reps_in  = '0;
            duty_wr  = '{write: 1'b1, duty: 8'd0};
         end
         default: ;
      endcase
   end

   // Hold sequencer state; advance on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff    <= '0;
         reps_ff     <= '0;
         on_ff       <= '0;
         off_ff      <= '0;
         sounding_ff <= 1'b0;
      end else if (fire) begin
         timer_ff    <= timer_in;
         reps_ff     <= reps_in;
         on_ff       <= on_in;
         off_ff      <= off_in;
         sounding_ff <= sounding_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/led_pwm_effects_with_buzzer_core.sv =====
// ----------------------------------------------------------------------------
// led_pwm_effects_with_buzzer_core
// Five-output PWM effects engine (brake, red, green, blue, buzzer).
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one command or one 10 ms tick per transfer.
//   Every transfer produces exactly one rsp_ transfer with the five pin
//   levels as they stand after that item.
//   An item taken into the input register moves on into the result register,
//   which raises rsp_valid, as soon as that register is empty or taken.
//   Throughput: one item per cycle. The item sits in an input register;
//   channel and buzzer updates plus the pin compares run in one pass into
//   the result register, bounded by the breathing multiply per channel.
//   When the receiver holds rsp_stall, the result register holds and one
//   more item waits in the input register; req_stall then rises.
//   Reset clears the counter, the buzzer timer and every channel (duty 0,
//   static mode, enabled, step 10); req_stall is high during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pwm_effects_with_buzzer_core import lpe_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_operation,
   input  wire logic [2:0]  req_channel,
   input  wire logic [7:0]  req_level,
   input  wire logic [15:0] req_speed,
   input  wire logic [1:0]  req_effect_mode,
   input  wire logic        req_enable_flag,
   input  wire logic [15:0] req_on_time_ms,
   input  wire logic [15:0] req_off_time_ms,
   input  wire logic [7:0]  req_repeat_count,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_brake_out,
   output logic             rsp_red_out,
   output logic             rsp_green_out,
   output logic             rsp_blue_out,
   output logic             rsp_buzzer_out
);

   localparam int PINS = 5;

   logic          in_valid_ff;
   cmd_type       cmd_ff, cmd_in;
   logic          rsp_valid_ff;
   logic [PINS-1:0] pins_ff;
   logic [7:0]    count_ff, count_in;

   logic          advance;
   logic          take;
   logic          fire;
   buzz_duty_type buzz_duty;
   logic [CHANNELS-1:0] chan_hit;
   logic [CHANNELS-1:0] chan_pin;
   logic [PINS-1:0]     pins_in;

   // Handshake: result register frees when empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign take      = !in_valid_ff || advance;
   assign fire      = in_valid_ff && advance;
   assign req_stall = reset || !take;

   // Pack the request; prescale the level for the breathing divide
   always_comb begin
      cmd_in.operation    = op_type'(req_operation);
      cmd_in.channel      = req_channel;
      cmd_in.level        = req_level;
      cmd_in.level_scaled = SCALED_WIDTH'(req_level) * SCALED_WIDTH'(RECIP);
      cmd_in.speed        = req_speed;
      cmd_in.effect_mode  = mode_type'(req_effect_mode);
      cmd_in.enable_flag  = req_enable_flag;
      cmd_in.on_time_ms   = req_on_time_ms;
      cmd_in.off_time_ms  = req_off_time_ms;
      cmd_in.repeat_count = req_repeat_count;
   end

   // Advance the shared PWM counter on a tick, wrapping 254 to 0
   always_comb begin
      count_in = count_ff;
      if (cmd_ff.operation == OP_TICK) begin
         count_in = (count_ff >= COUNT_TOP - 8'd1) ? 8'd0 : count_ff + 8'd1;
      end
   end

   lpe_buzzer u_buzzer (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .cmd     (cmd_ff),
      .duty_wr (buzz_duty)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      buzz_duty_type chan_buzz;

      assign chan_hit[c] = (32'(cmd_ff.channel) == c);
      assign chan_buzz   = (c == BUZZER_CH) ? buzz_duty : '0;

      lpe_channel u_channel (
         .clock     (clock),
         .reset     (reset),
         .fire      (fire),
         .cmd       (cmd_ff),
         .hit       (chan_hit[c]),
         .buzz_duty (chan_buzz),
         .count_in  (count_in),
         .pin_out   (chan_pin[c])
      );
   end

   // Map channels onto the five pins; missing channels read low
   for (genvar k = 0; k < PINS; k++) begin : g_pin
      if (k < CHANNELS) begin : g_present
         assign pins_in[k] = chan_pin[k];
      end else begin : g_absent
         assign pins_in[k] = 1'b0;
      end
   end

   // Input register and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (take) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_valid) begin
         cmd_ff <= cmd_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pins_ff <= pins_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_brake_out  = pins_ff[0];
   assign rsp_red_out    = pins_ff[1];
   assign rsp_green_out  = pins_ff[2];
   assign rsp_blue_out   = pins_ff[3];
   assign rsp_buzzer_out = pins_ff[4];

endmodule

`default_nettype wire

// ===== hw/rtl/lpe_checker.sv =====
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks of the LED PWM effects core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_pwm_effects_with_buzzer_core_assert.svh"

module lpe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_brake_out,
   input wire logic        rsp_red_out,
   input wire logic        rsp_green_out,
   input wire logic        rsp_blue_out,
   input wire logic        rsp_buzzer_out
);

   logic req_xfer;
   logic [4:0] pins;

   assign req_xfer = req_valid && !req_stall;
   assign pins     = {rsp_buzzer_out, rsp_blue_out, rsp_green_out, rsp_red_out,
                      rsp_brake_out};

   // A stalled result holds its pins
   `LPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(pins), "stalled result changed")

   // Every request transfer is followed by a shown result
   `LPE_ASSERT_AFTER2(a_rsp_latency, clock, reset, req_xfer, rsp_valid,
                      "result missing after request")

   // A new result only follows a request transfer
   `LPE_ASSERT_IMPLIES(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_xfer, 2),
                       "result without request")

   // Backpressure on the request side only comes from a stalled result
   `LPE_ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall,
                       "request stalled without cause")

endmodule

bind led_pwm_effects_with_buzzer_core lpe_checker u_lpe_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: LED PWM effects core with buzzer
// Sends commands and 10 ms ticks to the core under random idling on both
// channels. An in-bench model of the counter, channel effects and buzzer
// timer predicts the five pin levels for every transfer and checks each
// result in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpe_pkg::*;

   localparam int NUM_CH           = CHANNELS_DEFAULT;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int RANDOM_PER_PHASE = 376;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
   localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

   localparam logic [2:0] CH_BRAKE  = 3'd0;
   localparam logic [2:0] CH_RED    = 3'd1;
   localparam logic [2:0] CH_GREEN  = 3'd2;
   localparam logic [2:0] CH_BLUE   = 3'd3;
   localparam logic [2:0] CH_BUZZ   = 3'(BUZZER_CH);
   localparam logic [2:0] CH_ABSENT = 3'd7;

   typedef struct {
      logic [3:0]  operation;
      logic [2:0]  channel;
      logic [7:0]  level;
      logic [15:0] speed;
      logic [1:0]  effect_mode;
      logic        enable_flag;
      logic [15:0] on_time_ms;
      logic [15:0] off_time_ms;
      logic [7:0]  repeat_count;
   } req_item;

   // Pin-level predictor and in-order result check
   class pin_tracker;
      logic [7:0]  count;
      logic [7:0]  duty [NUM_CH];
      logic [7:0]  target [NUM_CH];
      logic [9:0]  phase [NUM_CH];
      logic [15:0] step [NUM_CH];
      mode_type    mode [NUM_CH];
      logic        enabled [NUM_CH];
      logic [15:0] buzz_timer;
      logic [7:0]  buzz_reps;
      logic [15:0] buzz_on;
      logic [15:0] buzz_off;
      logic        buzz_sounding;
      logic [4:0]  expected_pins [$];
      string       pin_names [5];
      int          mismatches;
      int          pins_checked;
      int          ticks;
      int          commands;
      int          noise;

      function new();
         int c;
         count = '0;
         for (c = 0; c < NUM_CH; c++) begin
            duty[c]    = '0;
            target[c]  = '0;
            phase[c]   = '0;
            step[c]    = STEP_RESET;
            mode[c]    = MODE_STATIC;
            enabled[c] = 1'b1;
         end
         buzz_timer    = '0;
         buzz_reps     = '0;
         buzz_on       = '0;
         buzz_off      = '0;
         buzz_sounding = 1'b0;
         pin_names     = '{"brake", "red", "green", "blue", "buzzer"};
         mismatches    = 0;
         pins_checked  = 0;
         ticks         = 0;
         commands      = 0;
         noise         = 0;
      endfunction

      function void set_buzz_duty(logic [7:0] d);
         if (BUZZER_CH < NUM_CH) duty[BUZZER_CH] = d;
      endfunction

      // Advance the phase; the 17-bit sum never saturates, restart at the wrap
      function void step_phase(int c);
         logic [16:0] sum;
         sum = {7'd0, phase[c]} + {1'b0, step[c]};
         if (sum >= 17'(PHASE_WRAP)) phase[c] = '0;
         else phase[c] = sum[9:0];
      endfunction

      function void channel_effect(int c);
         int unsigned d, tgt, sp, ph;
         d   = duty[c];
         tgt = target[c];
         sp  = step[c];
         case (mode[c])
            MODE_BREATH: begin
               step_phase(c);
               ph = phase[c];
               if (ph < PHASE_HALF) d = (ph * tgt) / PHASE_HALF;
               else d = ((PHASE_WRAP - ph) * tgt) / PHASE_HALF;
            end
            MODE_FLASH: begin
               step_phase(c);
               d = (phase[c] < PHASE_HALF) ? tgt : 0;
            end
            MODE_FADE: begin
               // move toward the target, never past it
               if (d < tgt) begin
                  d += sp;
                  if (d > tgt) d = tgt;
               end else if (d > tgt) begin
                  if (d >= sp && d - sp >= tgt) d -= sp;
                  else d = tgt;
               end
            end
            default: ;
         endcase
         if (d > 255) d = 255;
         duty[c] = 8'(d);
      endfunction

      // Count the buzzer timer down; at zero start the next beep phase
      function void buzzer_advance();
         if (buzz_timer == 0) return;
         buzz_timer = (buzz_timer > TICK_MS) ? buzz_timer - TICK_MS : '0;
         if (buzz_timer != 0) return;
         if (buzz_reps > 0) begin
            if (!buzz_sounding) begin
               buzz_sounding = 1'b1;
               buzz_timer    = buzz_on;
               set_buzz_duty(BUZZ_DUTY);
            end else begin
               buzz_sounding = 1'b0;
               buzz_timer    = buzz_off;
               set_buzz_duty('0);
               buzz_reps--;
            end
         end else begin
            set_buzz_duty('0);
         end
      endfunction

      // Apply one accepted item and queue the pin levels it leaves
      function void absorb_item(req_item it);
         logic [4:0] pins;
         int         c, k;
         bit         hit;
         hit = it.channel < NUM_CH;
         k   = hit ? int'(it.channel) : 0;
         if (it.operation == OP_TICK) ticks++;
         else if (it.operation > OP_STOP) noise++;
         else commands++;
         case (it.operation)
            OP_TICK: begin
               count = count + 8'd1;
               if (count >= COUNT_TOP) count = '0;
               for (c = 0; c < NUM_CH; c++)
                  if (enabled[c]) channel_effect(c);
               buzzer_advance();
            end
            OP_SET_DUTY: if (hit) begin
               duty[k]   = it.level;
               target[k] = it.level;
               mode[k]   = MODE_STATIC;
            end
            OP_SET_TARGET: if (hit) target[k] = it.level;
            OP_FADE: if (hit) begin
               target[k] = it.level;
               step[k]   = it.speed;
               mode[k]   = MODE_FADE;
            end
            OP_SET_MODE: if (hit) begin
               mode[k]  = mode_type'(it.effect_mode);
               step[k]  = it.speed;
               phase[k] = '0;
            end
            OP_ENABLE: if (hit) begin
               enabled[k] = it.enable_flag;
               if (!it.enable_flag) duty[k] = '0;
            end
            OP_BEEP: begin
               buzz_timer = it.on_time_ms;
               buzz_reps  = '0;
               set_buzz_duty(BUZZ_DUTY);
            end
            OP_PATTERN: begin
               buzz_reps     = it.repeat_count;
               buzz_on       = it.on_time_ms;
               buzz_off      = it.off_time_ms;
               buzz_sounding = 1'b0;
               buzz_timer    = 16'd1;
            end
            OP_STOP: begin
               buzz_timer = '0;
               buzz_reps  = '0;
               set_buzz_duty('0);
            end
            default: ;
         endcase
         for (c = 0; c < 5; c++)
            pins[c] = (c < NUM_CH) && enabled[c] && (count < duty[c]);
         expected_pins.push_back(pins);
      endfunction

      // Compare one result transfer with the oldest prediction
      function void compare_pins(logic [4:0] got);
         logic [4:0] want;
         int         c;
         pins_checked++;
         if (expected_pins.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with no prediction pending, pins %b", $realtime, got);
            return;
         end
         want = expected_pins.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               for (c = 0; c < 5; c++)
                  if (got[c] !== want[c])
                     $display("%0t: result %0d %s_out expected %b actual %b", $realtime,
                              pins_checked, pin_names[c], want[c], got[c]);
            end
         end
      endfunction
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [3:0]  req_operation    = '0;
   logic [2:0]  req_channel      = '0;
   logic [7:0]  req_level        = '0;
   logic [15:0] req_speed        = '0;
   logic [1:0]  req_effect_mode  = '0;
   logic        req_enable_flag  = 1'b0;
   logic [15:0] req_on_time_ms   = '0;
   logic [15:0] req_off_time_ms  = '0;
   logic [7:0]  req_repeat_count = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_brake_out;
   logic        rsp_red_out;
   logic        rsp_green_out;
   logic        rsp_blue_out;
   logic        rsp_buzzer_out;

   int          send_idle_pct  = 38;
   int          recv_stall_pct = 68;
   pin_tracker  tracker;

   led_pwm_effects_with_buzzer_core #(
      .CHANNELS(NUM_CH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_channel      (req_channel),
      .req_level        (req_level),
      .req_speed        (req_speed),
      .req_effect_mode  (req_effect_mode),
      .req_enable_flag  (req_enable_flag),
      .req_on_time_ms   (req_on_time_ms),
      .req_off_time_ms  (req_off_time_ms),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_brake_out    (rsp_brake_out),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_buzzer_out   (rsp_buzzer_out)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Note every transfer on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.absorb_item('{req_operation, req_channel, req_level, req_speed,
                                  req_effect_mode, req_enable_flag, req_on_time_ms,
                                  req_off_time_ms, req_repeat_count});
         if (rsp_valid && !rsp_stall)
            tracker.compare_pins({rsp_buzzer_out, rsp_blue_out, rsp_green_out,
                                  rsp_red_out, rsp_brake_out});
      end
   end

   // End the run when no transfer happens for too long
   initial begin
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("led_pwm_effects_with_buzzer_core verification failed");
      $finish;
   end

   function automatic req_item make_item(logic [3:0] op, logic [2:0] ch, logic [7:0] level,
                                         logic [15:0] speed, mode_type emode, logic en,
                                         logic [15:0] on_ms, logic [15:0] off_ms,
                                         logic [7:0] reps);
      req_item it;
      it.operation    = op;
      it.channel      = ch;
      it.level        = level;
      it.speed        = speed;
      it.effect_mode  = emode;
      it.enable_flag  = en;
      it.on_time_ms   = on_ms;
      it.off_time_ms  = off_ms;
      it.repeat_count = reps;
      return it;
   endfunction

   // Mostly short buzzer times so patterns run through, some full range
   function automatic logic [15:0] buzz_time();
      int pick;
      pick = $urandom_range(19);
      if (pick < 12) return 16'($urandom_range(60));
      if (pick < 17) return 16'($urandom_range(400));
      return 16'($urandom);
   endfunction

   function automatic req_item random_item();
      req_item it;
      int      pick;
      it.channel = ($urandom_range(99) < 85) ? 3'($urandom_range(NUM_CH - 1))
                                             : 3'($urandom_range(7, NUM_CH));
      if ($urandom_range(9) == 0) it.level = $urandom_range(1) ? 8'hFF : 8'h00;
      else it.level = 8'($urandom);
      pick = $urandom_range(3);
      if (pick < 2) it.speed = 16'($urandom_range(40, 1));
      else if (pick == 2) it.speed = 16'($urandom_range(1000));
      else it.speed = 16'($urandom);
      it.effect_mode  = 2'($urandom);
      it.enable_flag  = ($urandom_range(3) != 0);
      it.on_time_ms   = buzz_time();
      it.off_time_ms  = buzz_time();
      it.repeat_count = ($urandom_range(19) < 14) ? 8'($urandom_range(5)) : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 55) it.operation = OP_TICK;
      else if (pick < 63) it.operation = OP_SET_DUTY;
      else if (pick < 68) it.operation = OP_SET_TARGET;
      else if (pick < 74) it.operation = OP_FADE;
      else if (pick < 81) it.operation = OP_SET_MODE;
      else if (pick < 85) it.operation = OP_ENABLE;
      else if (pick < 89) it.operation = OP_BEEP;
      else if (pick < 94) it.operation = OP_PATTERN;
      else if (pick < 97) it.operation = OP_STOP;
      else it.operation = 4'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
      return it;
   endfunction

   // Unknown codes and channel commands to a missing channel change nothing
   function automatic bit is_ignored(req_item it);
      if (it.operation > OP_STOP) return 1'b1;
      return it.channel >= NUM_CH && it.operation >= OP_SET_DUTY &&
             it.operation <= OP_ENABLE;
   endfunction

   // Drive one item from a falling edge and hold it until the transfer
   task automatic apply_item(input req_item it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_operation    = it.operation;
      req_channel      = it.channel;
      req_level        = it.level;
      req_speed        = it.speed;
      req_effect_mode  = it.effect_mode;
      req_enable_flag  = it.enable_flag;
      req_on_time_ms   = it.on_time_ms;
      req_off_time_ms  = it.off_time_ms;
      req_repeat_count = it.repeat_count;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Hold the sender until every predicted result is back
   task automatic wait_for_pins();
      req_valid = 1'b0;
      while (tracker.expected_pins.size() != 0) @(negedge clock);
   endtask

   task automatic run_directed();
      req_item plan [$];
      plan.push_back(make_item(OP_SET_DUTY, CH_BRAKE, 8'hFF, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_TICK, CH_BRAKE, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      // fade down from 200 clamps at the target of 10
      plan.push_back(make_item(OP_SET_DUTY, CH_RED, 8'd200, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_FADE, CH_RED, 8'd10, 16'd100, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_TICK, CH_RED, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_TICK, CH_RED, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      // fade up with the largest step stops at the target
      plan.push_back(make_item(OP_FADE, CH_GREEN, 8'hFF, 16'hFFFF, MODE_STATIC, 1'b1,
                               16'hFFFF, 16'hFFFF, 8'hFF));
      plan.push_back(make_item(OP_TICK, CH_GREEN, 8'hFF, 16'hFFFF, MODE_FADE, 1'b1,
                               16'hFFFF, 16'hFFFF, 8'hFF));
      // breathing with the largest step wraps the phase at once
      plan.push_back(make_item(OP_SET_MODE, CH_BLUE, 8'h0, 16'hFFFF, MODE_BREATH, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_SET_TARGET, CH_BLUE, 8'hFF, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_TICK, CH_BLUE, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_SET_MODE, CH_BLUE, 8'h0, 16'd300, MODE_FLASH, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_TICK, CH_BLUE, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_SET_MODE, CH_BRAKE, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      // disable clears the duty, enable brings the channel back
      plan.push_back(make_item(OP_ENABLE, CH_RED, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_ENABLE, CH_RED, 8'h0, 16'h0, MODE_STATIC, 1'b1,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_BEEP, CH_BUZZ, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'hFFFF, 16'h0, 8'h0));
      plan.push_back(make_item(OP_TICK, CH_BUZZ, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      // a pattern with zero on time keeps sounding
      plan.push_back(make_item(OP_PATTERN, CH_BUZZ, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'hFF));
      plan.push_back(make_item(OP_TICK, CH_BUZZ, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_TICK, CH_BUZZ, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_STOP, CH_BUZZ, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      // unknown codes and a missing channel change nothing
      plan.push_back(make_item(OP_UNKNOWN_HI, CH_ABSENT, 8'hFF, 16'hFFFF, MODE_FADE, 1'b1,
                               16'hFFFF, 16'hFFFF, 8'hFF));
      plan.push_back(make_item(OP_UNKNOWN_LO, CH_BRAKE, 8'h0, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      plan.push_back(make_item(OP_SET_DUTY, CH_ABSENT, 8'hFF, 16'h0, MODE_STATIC, 1'b0,
                               16'h0, 16'h0, 8'h0));
      foreach (plan[i]) apply_item(plan[i]);
   endtask

   initial begin
      int stage;
      int useful;
      tracker = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      // three idling profiles: receiver-heavy stalls, sender-heavy gaps, none
      for (stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               send_idle_pct  = 38;
               recv_stall_pct = 68;
            end
            1: begin
               send_idle_pct  = 68;
               recv_stall_pct = 38;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         useful = 0;
         while (useful < RANDOM_PER_PHASE) begin
            req_item it;
            it = random_item();
            if (!is_ignored(it)) useful++;
            apply_item(it);
         end
         wait_for_pins();
      end
      repeat (8) @(negedge clock);
      $display("Sent %0d ticks, %0d commands and %0d unknown codes; checked %0d results",
               tracker.ticks, tracker.commands, tracker.noise, tracker.pins_checked);
      $display("Mismatching results: %0d", tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.expected_pins.size() == 0) begin
         $display("led_pwm_effects_with_buzzer_core verification clean");
      end else begin
         $display("led_pwm_effects_with_buzzer_core verification failed");
      end
      $finish;
   end

endmodule
